@@ hw/rtl/chse_pkg.sv @@
package chse_pkg;

  localparam int NUM_COLS = 8;
  localparam int NUM_NIB  = 5;
  localparam int SYM_W    = 7;
  localparam int HDR_W    = 12;
  localparam int SF_W     = 3;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // Byte address of the spreading factor register.
  localparam logic [ADDR_W-1:0] ADDR_SF  = 3'd0;
  localparam logic [SF_W-1:0]   SF_RESET = 3'd7;

  // Checksum rows over the twelve header bits; row 0 gives checksum bit 4.
  localparam logic [HDR_W-1:0] CHK_MASK [NUM_NIB] = '{
    12'hC52, 12'h516, 12'h524, 12'hC51, 12'hCEB
  };

  typedef enum logic [1:0] {
    ROWS_3,
    ROWS_4,
    ROWS_5
  } rows_t;

  typedef struct packed {
    logic  valid;
    rows_t rows;
  } stage_ctl_t;

  typedef logic [NUM_NIB-1:0][7:0]        cw_set_t;
  typedef logic [NUM_COLS-1:0][SYM_W-1:0] sym_set_t;

  function automatic logic [2:0] cr_pattern(input logic [2:0] cr);
    logic [2:0] pat;
    case (cr) inside
      3'd0, 3'd1: pat = 3'b100;
      3'd2:       pat = 3'b010;
      3'd3:       pat = 3'b110;
      default:    pat = 3'b001;
    endcase
    return pat;
  endfunction

  function automatic rows_t rows_from_sf(input logic [SF_W-1:0] sf);
    rows_t rows;
    case (sf) inside
      [3'd0:3'd5]: rows = ROWS_3;
      3'd6:        rows = ROWS_4;
      default:     rows = ROWS_5;
    endcase
    return rows;
  endfunction

  function automatic logic [7:0] ham84(input logic [3:0] n);
    logic p0, p1, p2, p3;
    p0 = n[3] ^ n[2] ^ n[1];
    p1 = n[2] ^ n[1] ^ n[0];
    p2 = n[3] ^ n[2] ^ n[0];
    p3 = n[3] ^ n[1] ^ n[0];
    return {n, p0, p1, p2, p3};
  endfunction

endpackage

@@ hw/rtl/chirp_header_symbol_encoder.sv @@
// Channel   | Handshake                  | Payload
// ----------+----------------------------+---------------------------------------------
// request   | start, busy                | length_bytes, coding_rate, crc_present
// result    | done (one-cycle strobe)    | symbol_0 .. symbol_7
// config    | psel, penable, pwrite, ... | paddr, pwdata, prdata
//
// A word is accepted on any cycle with start high; busy is always low, so one word a cycle.
// Each result passes through the stages of header fields, then checksum and Hamming
// coding, then interleaving and parity, each stage ending in a register.
// Reset clears the stage valid bits and sets the spreading factor to 7.
// The receiver cannot stall; done marks each result for exactly one cycle.
module chirp_header_symbol_encoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [7:0]                     length_bytes,
  input  logic [2:0]                     coding_rate,
  input  logic                           crc_present,
  output logic                           done,
  output logic [chse_pkg::SYM_W-1:0]     symbol_0,
  output logic [chse_pkg::SYM_W-1:0]     symbol_1,
  output logic [chse_pkg::SYM_W-1:0]     symbol_2,
  output logic [chse_pkg::SYM_W-1:0]     symbol_3,
  output logic [chse_pkg::SYM_W-1:0]     symbol_4,
  output logic [chse_pkg::SYM_W-1:0]     symbol_5,
  output logic [chse_pkg::SYM_W-1:0]     symbol_6,
  output logic [chse_pkg::SYM_W-1:0]     symbol_7,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [chse_pkg::ADDR_W-1:0]    paddr,
  input  logic [chse_pkg::DATA_W-1:0]    pwdata,
  output logic [chse_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import chse_pkg::*;

  logic [SF_W-1:0]  sf;
  logic             accept;

  stage_ctl_t       ctl1;
  logic [HDR_W-1:0] hdr1;

  logic [4:0]       chk;
  logic [3:0]       nib [NUM_NIB];
  cw_set_t          cw_next;
  stage_ctl_t       ctl2;
  cw_set_t          cw2;

  sym_set_t         syms;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      sf <= SF_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_SF) begin
      sf <= pwdata[SF_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_SF) ? {{(DATA_W-SF_W){1'b0}}, sf} : '0;

  // Stage 1: header bits, with bit i of the word being header bit i.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else begin
      ctl1.valid <= accept;
    end
    if (accept) begin
      ctl1.rows <= rows_from_sf(sf);
      hdr1      <= {crc_present, cr_pattern(coding_rate), length_bytes};
    end
  end

  // Stage 2: checksum and Hamming coding of all five nibbles.
  always_comb begin
    for (int r = 0; r < NUM_NIB; r++) begin
      chk[NUM_NIB-1-r] = ^(hdr1 & CHK_MASK[r]);
    end
    nib[0] = hdr1[7:4];
    nib[1] = hdr1[3:0];
    nib[2] = {hdr1[10:8], hdr1[11]};
    nib[3] = {3'b000, chk[4]};
    nib[4] = chk[3:0];
    for (int r = 0; r < NUM_NIB; r++) begin
      cw_next[r] = ham84(nib[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl2.valid <= 1'b0;
    end else begin
      ctl2.valid <= ctl1.valid;
    end
    if (ctl1.valid) begin
      ctl2.rows <= ctl1.rows;
      cw2       <= cw_next;
    end
  end

  // Stage 3: diagonal interleave, parity and packing.
  chse_interleave u_interleave (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl2),
    .cw   (cw2),
    .done (done),
    .syms (syms)
  );

  assign symbol_0 = syms[0];
  assign symbol_1 = syms[1];
  assign symbol_2 = syms[2];
  assign symbol_3 = syms[3];
  assign symbol_4 = syms[4];
  assign symbol_5 = syms[5];
  assign symbol_6 = syms[6];
  assign symbol_7 = syms[7];

endmodule

@@ hw/rtl/chse_interleave.sv @@
module chse_interleave (
  input  logic                clk,
  input  logic                rst,
  input  chse_pkg::stage_ctl_t ctl,
  input  chse_pkg::cw_set_t   cw,
  output logic                done,
  output chse_pkg::sym_set_t  syms
);
  import chse_pkg::*;

  // Interleaved bits for each possible row count, most significant row slot first.
  logic [NUM_NIB-1:0] ilv [3][NUM_COLS];
  sym_set_t           syms_next;

  for (genvar gr = 0; gr < 3; gr++) begin : g_rows
    localparam int R = gr + 3;
    for (genvar gc = 0; gc < NUM_COLS; gc++) begin : g_col
      for (genvar gj = 0; gj < NUM_NIB; gj++) begin : g_slot
        if (gj < R) begin : g_used
          localparam int Src = (gc + 2 * R - gj - 1) % R;
          assign ilv[gr][gc][R-1-gj] = cw[Src][7-gc];
        end else begin : g_unused
          assign ilv[gr][gc][gj] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      case (ctl.rows)
        ROWS_3:  syms_next[c] = {2'b00, ilv[0][c][2:0], ^ilv[0][c][2:0], 1'b0};
        ROWS_4:  syms_next[c] = {1'b0, ilv[1][c][3:0], ^ilv[1][c][3:0], 1'b0};
        default: syms_next[c] = {ilv[2][c], ^ilv[2][c], 1'b0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      syms <= syms_next;
    end
  end

endmodule

@@ hw/rtl/chse_checker.sv @@
module chse_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic                        done,
  input logic [chse_pkg::SYM_W-1:0]  symbol_0,
  input logic [chse_pkg::SYM_W-1:0]  symbol_7
);
  import chse_pkg::*;

  // Every accepted word yields its result through the stage 1, stage 2 and done registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("accepted word gave no result after three cycles");

  // No result appears without a word accepted ahead of it through the stage 1, stage 2 and done registers.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 3))
    else $error("result without a matching request");

  // The last bit of symbols 0 and 7 is the fixed zero.
  a_tail_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> (symbol_0[0] == 1'b0 && symbol_7[0] == 1'b0))
    else $error("symbol tail bit is not zero");

  // The block never refuses a word.
  a_never_busy: assert property (@(posedge clk) disable iff (rst)
    !busy)
    else $error("busy raised");

endmodule

bind chirp_header_symbol_encoder chse_checker u_chse_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .symbol_0 (symbol_0),
  .symbol_7 (symbol_7)
);

@@ tb/chirp_header_symbol_encoder_tb.sv @@
module chirp_header_symbol_encoder_tb;
  import chse_pkg::*;

  // Three-bit coding-rate patterns carried in the third header nibble.
  localparam logic [2:0] PAT_CR_4_5 = 3'b100;
  localparam logic [2:0] PAT_CR_4_6 = 3'b010;
  localparam logic [2:0] PAT_CR_4_7 = 3'b110;
  localparam logic [2:0] PAT_CR_4_8 = 3'b001;

  // Word address with no register behind it.
  localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'd4;

  localparam int N_DIRECTED = 20;

  typedef struct packed {
    logic [7:0] len;
    logic [2:0] cr;
    logic       crc;
    logic       fixed;
    sym_set_t   sym;
  } header_row_t;

  // Only the first row carries a hand-worked result: length 0, rate 4/8, no CRC, at sf 7.
  localparam header_row_t DIRECTED [N_DIRECTED] = '{
    '{8'h00, 3'd4, 1'b0, 1'b1,
      {7'h14, 7'h00, 7'h50, 7'h22, 7'h00, 7'h06, 7'h22, 7'h42}},
    '{8'h00, 3'd0, 1'b0, 1'b0, '0},
    '{8'h00, 3'd1, 1'b1, 1'b0, '0},
    '{8'hFF, 3'd2, 1'b0, 1'b0, '0},
    '{8'hFF, 3'd3, 1'b1, 1'b0, '0},
    '{8'hFF, 3'd4, 1'b1, 1'b0, '0},
    '{8'h0F, 3'd5, 1'b0, 1'b0, '0},
    '{8'hF0, 3'd6, 1'b1, 1'b0, '0},
    '{8'hAA, 3'd7, 1'b0, 1'b0, '0},
    '{8'h55, 3'd7, 1'b1, 1'b0, '0},
    '{8'h80, 3'd1, 1'b0, 1'b0, '0},
    '{8'h01, 3'd2, 1'b1, 1'b0, '0},
    '{8'h7F, 3'd3, 1'b0, 1'b0, '0},
    '{8'hFE, 3'd0, 1'b1, 1'b0, '0},
    '{8'h00, 3'd7, 1'b1, 1'b0, '0},
    '{8'hFF, 3'd0, 1'b0, 1'b0, '0},
    '{8'h10, 3'd4, 1'b0, 1'b0, '0},
    '{8'h08, 3'd5, 1'b1, 1'b0, '0},
    '{8'hC3, 3'd6, 1'b0, 1'b0, '0},
    '{8'h3C, 3'd2, 1'b1, 1'b0, '0}
  };

  localparam logic [SF_W-1:0] SF_PLAN [10] = '{
    3'd5, 3'd0, 3'd6, 3'd4, 3'd7, 3'd1, 3'd6, 3'd2, 3'd5, 3'd3
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [7:0]        length_bytes = '0;
  logic [2:0]        coding_rate = '0;
  logic              crc_present = 1'b0;
  logic              done;
  logic [SYM_W-1:0]  symbol_0, symbol_1, symbol_2, symbol_3;
  logic [SYM_W-1:0]  symbol_4, symbol_5, symbol_6, symbol_7;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  logic [SF_W-1:0]   sf_setting = SF_RESET;
  sym_set_t          pending_symbols [$];
  int                mismatch_count = 0;

  chirp_header_symbol_encoder uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .length_bytes(length_bytes), .coding_rate(coding_rate), .crc_present(crc_present),
    .done(done),
    .symbol_0(symbol_0), .symbol_1(symbol_1), .symbol_2(symbol_2), .symbol_3(symbol_3),
    .symbol_4(symbol_4), .symbol_5(symbol_5), .symbol_6(symbol_6), .symbol_7(symbol_7),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] hamming_8_4(input logic [3:0] n);
    return {n, n[3] ^ n[2] ^ n[1], n[2] ^ n[1] ^ n[0],
            n[3] ^ n[2] ^ n[0], n[3] ^ n[1] ^ n[0]};
  endfunction

  function automatic sym_set_t encode_header_symbols(input logic [SF_W-1:0] sf_reg,
                                                     input logic [7:0] len,
                                                     input logic [2:0] cr,
                                                     input logic crc);
    int          rows;
    int          src;
    logic [2:0]  pat;
    logic [11:0] hdr;
    logic [4:0]  chk;
    logic [7:0]  cw [NUM_NIB];
    logic [6:0]  sym;
    logic        par;
    logic        b;
    sym_set_t    res;
    rows = (sf_reg < 3'd5) ? 3 : int'(sf_reg) - 2;
    case (cr)
      3'd0, 3'd1: pat = PAT_CR_4_5;
      3'd2:       pat = PAT_CR_4_6;
      3'd3:       pat = PAT_CR_4_7;
      default:    pat = PAT_CR_4_8;
    endcase
    hdr = {crc, pat, len};
    for (int r = 0; r < NUM_NIB; r++) chk[4-r] = ^(hdr & CHK_MASK[r]);
    cw[0] = hamming_8_4(len[7:4]);
    cw[1] = hamming_8_4(len[3:0]);
    cw[2] = hamming_8_4({pat, crc});
    cw[3] = hamming_8_4({3'b000, chk[4]});
    cw[4] = hamming_8_4(chk[3:0]);
    for (int col = 0; col < NUM_COLS; col++) begin
      sym = '0;
      par = 1'b0;
      // Diagonal interleave: row slot j of column col reads codeword (col - j - 1) mod rows.
      for (int j = 0; j < rows; j++) begin
        src = (col + 2 * rows - j - 1) % rows;
        b = cw[src][7-col];
        sym = {sym[5:0], b};
        par ^= b;
      end
      res[col] = {sym[4:0], par, 1'b0};
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    sym_set_t seen;
    sym_set_t want;
    if (!rst && done) begin
      seen = {symbol_7, symbol_6, symbol_5, symbol_4, symbol_3, symbol_2, symbol_1, symbol_0};
      if (pending_symbols.size() == 0) begin
        flag_mismatch("unexpected word", int'(seen[0]), 0);
      end else begin
        want = pending_symbols.pop_front();
        for (int k = 0; k < NUM_COLS; k++)
          if (seen[k] !== want[k])
            flag_mismatch($sformatf("symbol_%0d", k), int'(seen[k]), int'(want[k]));
      end
    end
  end

  task automatic send_header(input logic [7:0] len, input logic [2:0] cr, input logic crc,
                             input logic fixed, input sym_set_t fixed_sym, input int gap);
    length_bytes   <= len;
    coding_rate    <= cr;
    crc_present    <= crc;
    start          <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    pending_symbols.insert(pending_symbols.size(),
                           fixed ? fixed_sym : encode_header_symbols(sf_setting, len, cr, crc));
    if (gap > 0) begin
      start <= 1'b0;
      // Fields wander while start is low; the block must not take them.
      repeat (gap) begin
        length_bytes   <= 8'($urandom());
        coding_rate    <= 3'($urandom());
        crc_present    <= 1'($urandom());
        @(posedge clk);
      end
    end
  endtask

  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    if (start) start <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_SF) sf_setting = data[SF_W-1:0];
  endtask

  task automatic walk_directed();
    for (int i = 0; i < N_DIRECTED; i++)
      send_header(DIRECTED[i].len, DIRECTED[i].cr, DIRECTED[i].crc,
                  DIRECTED[i].fixed && sf_setting == 3'd7, DIRECTED[i].sym,
                  (i % 4 == 3) ? int'($urandom_range(1, 9)) : 0);
  endtask

  task automatic run_random(input int count, input bit idle_on);
    for (int i = 0; i < count; i++)
      send_header(8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)), 1'b0, '0,
                  (idle_on && $urandom_range(0, 3) == 0) ? int'($urandom_range(1, 9)) : 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    walk_directed();
    // A write to an empty address must leave the spreading factor at 7.
    write_reg(ADDR_UNUSED, $urandom());
    run_random(60, 1'b1);
    for (int p = 0; p < 10; p++) begin
      write_reg(ADDR_SF, ($urandom() & ~32'h7) | DATA_W'(SF_PLAN[p]));
      if (p == 0) walk_directed();
      run_random(120, p % 3 != 2);
    end
    write_reg(ADDR_SF, ($urandom() & ~32'h7) | DATA_W'(3'd7));
    run_random(150, 1'b0);
    start <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_symbols.size() == 0) begin
      $display("chirp_header_symbol_encoder_tb: clean");
    end else begin
      $display("chirp_header_symbol_encoder_tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("chirp_header_symbol_encoder_tb: errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/chse_pkg.sv
hw/rtl/chse_interleave.sv
hw/rtl/chirp_header_symbol_encoder.sv
hw/rtl/chse_checker.sv
tb/chirp_header_symbol_encoder_tb.sv
